### sv/vdc_pkg.sv
// Shared definitions for the vertical delta codec: sizes, register indexes,
// lane codes, the column-tracking struct and the lane-wise add/subtract.
// No dependencies.
package vdc_pkg;

    // Line store geometry
    localparam int MAX_ROW_WORDS = 512;
    localparam int ADDR_W        = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int CNT_W         = $clog2(MAX_ROW_WORDS + 1);

    // Payload and configuration widths
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int ROW_W      = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WORDS   = 2'd2;

    // Lane width codes (anything else means eight-bit lanes)
    localparam logic [1:0] LANE_8  = 2'd0;
    localparam logic [1:0] LANE_16 = 2'd1;
    localparam logic [1:0] LANE_32 = 2'd2;

    localparam logic [ROW_W-1:0] ROW_WORDS_RESET = 10'd2;

    // Column position of one accepted word
    typedef struct packed {
        logic [ADDR_W-1:0] col;
        logic              first_row;
    } t_col_info;

    // Lane-wise wrapping a + b (add) or a - b (subtract)
    function automatic logic [WORD_W-1:0] lane_combine(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [1:0]        lane,
        input logic              add
    );
        logic [WORD_W-1:0] r8;
        logic [WORD_W-1:0] r16;
        logic [WORD_W-1:0] r32;
        logic [WORD_W-1:0] res;
        for (int i = 0; i < WORD_W / 8; i++) begin
            r8[i*8 +: 8] = add ? (a[i*8 +: 8] + b[i*8 +: 8]) : (a[i*8 +: 8] - b[i*8 +: 8]);
        end
        for (int i = 0; i < WORD_W / 16; i++) begin
            r16[i*16 +: 16] = add ? (a[i*16 +: 16] + b[i*16 +: 16])
                                  : (a[i*16 +: 16] - b[i*16 +: 16]);
        end
        for (int i = 0; i < WORD_W / 32; i++) begin
            r32[i*32 +: 32] = add ? (a[i*32 +: 32] + b[i*32 +: 32])
                                  : (a[i*32 +: 32] - b[i*32 +: 32]);
        end
        case (lane)
            LANE_16: res = r16;
            LANE_32: res = r32;
            default: res = r8;
        endcase
        return res;
    endfunction

endpackage

### sv/vdc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// A read at the address being written returns the old contents. No dependencies.
module vdc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, and read port that holds its data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/vdc_col_tracker.sv
// Column and first-row tracking for the vertical delta codec: gives each
// accepted word its line store column. Depends on vdc_pkg.
module vdc_col_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_frame_start,
    input  logic [vdc_pkg::ROW_W-1:0]      i_row_words,
    output vdc_pkg::t_col_info             o_info
);

    logic [vdc_pkg::ADDR_W-1:0] r_col;
    logic [vdc_pkg::ADDR_W-1:0] n_col;
    logic                       r_first;
    logic                       n_first;
    logic [vdc_pkg::CNT_W-1:0]  row_eff;
    logic [vdc_pkg::CNT_W-1:0]  col_start;
    logic [vdc_pkg::CNT_W-1:0]  col_now;
    logic [vdc_pkg::CNT_W-1:0]  col_next;
    logic                       first_start;
    logic                       first_now;

    // Clamp row length: zero acts as one, oversize saturates
    always_comb begin
        if (i_row_words == '0) begin
            row_eff = vdc_pkg::CNT_W'(1);
        end else if (int'(i_row_words) > vdc_pkg::MAX_ROW_WORDS) begin
            row_eff = vdc_pkg::CNT_W'(vdc_pkg::MAX_ROW_WORDS);
        end else begin
            row_eff = vdc_pkg::CNT_W'(i_row_words);
        end
    end

    // Column of this word and position of the next one
    always_comb begin
        col_start   = i_frame_start ? '0 : vdc_pkg::CNT_W'(r_col);
        first_start = i_frame_start | r_first;
        if (col_start >= row_eff) begin
            col_now   = '0;
            first_now = 1'b0;
        end else begin
            col_now   = col_start;
            first_now = first_start;
        end
        col_next = col_now + vdc_pkg::CNT_W'(1);
        if (col_next >= row_eff) begin
            n_col   = '0;
            n_first = 1'b0;
        end else begin
            n_col   = col_next[vdc_pkg::ADDR_W-1:0];
            n_first = first_now;
        end
    end

    assign o_info.col       = col_now[vdc_pkg::ADDR_W-1:0];
    assign o_info.first_row = first_now;

    // Advance the position on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

endmodule

### sv/vdc_datapath.sv
// Datapath of the vertical delta codec: input stage that meets the line store
// read, lane-wise add/subtract, write-back and output register.
// Depends on vdc_pkg.
module vdc_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [vdc_pkg::WORD_W-1:0]       i_word,
    input  vdc_pkg::t_col_info               i_info,
    input  logic                             i_decode_mode,
    input  logic [1:0]                       i_lane_width,
    input  logic                             i_out_ready,
    input  logic [vdc_pkg::WORD_W-1:0]       i_rd_data,
    output logic                             o_in_ready,
    output logic                             o_out_valid,
    output logic [vdc_pkg::WORD_W-1:0]       o_out_data,
    output logic                             o_rd_en,
    output logic [vdc_pkg::ADDR_W-1:0]       o_rd_addr,
    output logic                             o_wr_en,
    output logic [vdc_pkg::ADDR_W-1:0]       o_wr_addr,
    output logic [vdc_pkg::WORD_W-1:0]       o_wr_data
);

    logic                         r_a_valid;
    logic [vdc_pkg::WORD_W-1:0]   r_a_word;
    logic [vdc_pkg::ADDR_W-1:0]   r_a_col;
    logic                         r_a_first;
    logic                         r_a_fwd;
    logic [vdc_pkg::WORD_W-1:0]   r_a_fwd_data;
    logic                         r_b_valid;
    logic [vdc_pkg::WORD_W-1:0]   r_b_data;
    logic                         a_adv;
    logic [vdc_pkg::WORD_W-1:0]   above;
    logic [vdc_pkg::WORD_W-1:0]   result;
    logic [vdc_pkg::WORD_W-1:0]   store;

    assign a_adv      = r_a_valid & (~r_b_valid | i_out_ready);
    assign o_in_ready = ~r_a_valid | a_adv;

    // Read the word above as the item enters the input stage
    assign o_rd_en   = i_accept;
    assign o_rd_addr = i_info.col;

    // Word above: zero on a first row, bypass when the same column was just written
    always_comb begin
        if (r_a_first) begin
            above = '0;
        end else if (r_a_fwd) begin
            above = r_a_fwd_data;
        end else begin
            above = i_rd_data;
        end
        result = vdc_pkg::lane_combine(r_a_word, above, i_lane_width, i_decode_mode);
        store  = i_decode_mode ? result : r_a_word;
    end

    // Write back as the item leaves the input stage
    assign o_wr_en   = a_adv;
    assign o_wr_addr = r_a_col;
    assign o_wr_data = store;

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_word     <= i_word;
            r_a_col      <= i_info.col;
            r_a_first    <= i_info.first_row;
            r_a_fwd      <= a_adv && (r_a_col == i_info.col);
            r_a_fwd_data <= store;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_data <= result;
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_out_data  = r_b_data;

endmodule

### sv/vertical_delta_codec.sv
// Vertical delta codec top level: configuration registers, column tracker,
// line store RAM and datapath. Depends on vdc_pkg, vdc_ram, vdc_col_tracker
// and vdc_datapath.
//
// Up-prediction filter on a raster stream of 64-bit words. Encoding replaces
// each word with its lane-wise wrapping difference from the raw word one row
// above; decoding adds the reconstructed word above. Lanes are 8, 16 or 32
// bits; the first row of a frame (tuser high on its first word) predicts
// from zero. The block takes one word per clock cycle, back to back, while
// results are taken, and each result is offered from the output register:
// the line store read is registered together with the input word in the
// input stage, and the output register follows it. Input stalls only while
// the output register holds a result that is not taken. The line store is a
// 512 x 64 RAM with one write and one read port; a word whose column was
// written by the word just before it (one-word rows) is bypassed around the
// RAM. The line store needs no clearing pass after reset. Configuration is
// always ready and must only be written while the block is idle.
module vertical_delta_codec (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [63:0]                        s_axis_tdata,   // [63:0] pixel_word
    input  logic [0:0]                         s_axis_tuser,   // [0] frame_start
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [63:0]                        m_axis_tdata,   // [63:0] coded_word
    // Configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                           r_decode_mode;
    logic [1:0]                     r_lane_width;
    logic [vdc_pkg::ROW_W-1:0]      r_row_words;
    logic                           in_accept;
    vdc_pkg::t_col_info             col_info;
    logic                           rd_en;
    logic [vdc_pkg::ADDR_W-1:0]     rd_addr;
    logic [vdc_pkg::WORD_W-1:0]     rd_data;
    logic                           wr_en;
    logic [vdc_pkg::ADDR_W-1:0]     wr_addr;
    logic [vdc_pkg::WORD_W-1:0]     wr_data;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = s_axis_tvalid & s_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_lane_width  <= vdc_pkg::LANE_8;
            r_row_words   <= vdc_pkg::ROW_WORDS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vdc_pkg::CFG_DECODE_MODE: r_decode_mode <= i_cfg_data[0];
                vdc_pkg::CFG_LANE_WIDTH:  r_lane_width  <= i_cfg_data[1:0];
                vdc_pkg::CFG_ROW_WORDS:   r_row_words   <= i_cfg_data[vdc_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    vdc_col_tracker u_col_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_frame_start (s_axis_tuser[0]),
        .i_row_words   (r_row_words),
        .o_info        (col_info)
    );

    vdc_ram #(
        .WIDTH (vdc_pkg::WORD_W),
        .DEPTH (vdc_pkg::MAX_ROW_WORDS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    vdc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_word        (s_axis_tdata),
        .i_info        (col_info),
        .i_decode_mode (r_decode_mode),
        .i_lane_width  (r_lane_width),
        .i_out_ready   (m_axis_tready),
        .i_rd_data     (rd_data),
        .o_in_ready    (s_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

endmodule

### sv/vdc_checker.sv
// Port-level checks for the vertical delta codec, bound to the top level.
// Depends on vertical_delta_codec.
module vdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // Come out of reset empty and ready for a transfer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // Stall input only when the output side is full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // A transfer in while the output is stalled keeps a result pending on the next cycle
    a_accept_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready
            |=> m_axis_tvalid)
        else $error("result lost after input transfer");

endmodule

bind vertical_delta_codec vdc_checker u_vdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
